### design/pbs_pkg.sv
// Shared types and constants for the PWM-synchronized back-EMF sampler.
`timescale 1ns / 1ps
`default_nettype none
package pbs_pkg;
	localparam int SAMPLE_W = 10;
	localparam int VAL_W    = 16;
	localparam int PROD_W   = SAMPLE_W + VAL_W;
	localparam int QEST_W   = VAL_W + 1;

	localparam logic [PROD_W:0] FULL_SCALE = (PROD_W + 1)'(1023);

	localparam logic [1:0] OP_BOTTOM = 2'd0;
	localparam logic [1:0] OP_TOP    = 2'd1;
	localparam logic [1:0] OP_DONE   = 2'd2;

	localparam logic [1:0] REG_PWM_TOP      = 2'd0;
	localparam logic [1:0] REG_SUPPLY_MV    = 2'd1;
	localparam logic [1:0] REG_REPORT_EVERY = 2'd2;

	localparam logic [VAL_W-1:0] PWM_TOP_RST      = 16'd1000;
	localparam logic [VAL_W-1:0] SUPPLY_MV_RST    = 16'd5000;
	localparam logic [VAL_W-1:0] REPORT_EVERY_RST = 16'd50;

	typedef struct packed {
		logic [1:0]          operation;
		logic [SAMPLE_W-1:0] sample;
	} evt_t;

	typedef struct packed {
		logic             start_conv;
		logic             conv_channel;
		logic             duty_valid;
		logic [VAL_W-1:0] duty;
		logic             report_valid;
		logic [VAL_W-1:0] on_mv;
		logic [VAL_W-1:0] emf_mv;
	} res_t;

	// stage load enables for the arithmetic pipeline
	typedef struct packed {
		logic s1;
		logic s2;
	} adv_t;

	typedef struct packed {
		logic start;
		logic chan;
		logic dvalid;
		logic rvalid;
		logic hold;
	} ctl_t;
endpackage
`default_nettype wire

### design/pbs_scale.sv
// Two-stage scaling unit: raw*factor, then truncating divide by 1023.
`timescale 1ns / 1ps
`default_nettype none
module pbs_scale (
	input  wire logic                          clk,
	input  wire pbs_pkg::adv_t                 adv,
	input  wire logic [pbs_pkg::SAMPLE_W-1:0]  raw,
	input  wire logic [pbs_pkg::VAL_W-1:0]     factor,
	output logic      [pbs_pkg::VAL_W-1:0]     quo
);
	logic [pbs_pkg::PROD_W-1:0] prod_s1;
	logic [pbs_pkg::PROD_W-1:0] prod_s2;
	logic [pbs_pkg::PROD_W:0]   est_sum;
	logic [pbs_pkg::QEST_W-1:0] qest;
	logic [pbs_pkg::QEST_W-1:0] qest_s2;
	logic [pbs_pkg::PROD_W:0]   rem;
	logic [pbs_pkg::QEST_W-1:0] qfix;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_s1 <= pbs_pkg::PROD_W'(raw) * pbs_pkg::PROD_W'(factor);
		end
	end

	// x/1023 ~ (x + x/2^10 + x/2^20) / 2^10, low by at most one
	always_comb begin
		est_sum = (pbs_pkg::PROD_W + 1)'(prod_s1)
			+ (pbs_pkg::PROD_W + 1)'(prod_s1 >> 10)
			+ (pbs_pkg::PROD_W + 1)'(prod_s1 >> 20);
		qest = est_sum[pbs_pkg::PROD_W:10];
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= prod_s1;
			qest_s2 <= qest;
		end
	end

	always_comb begin
		rem = (pbs_pkg::PROD_W + 1)'(prod_s2)
			- ({qest_s2, 10'b0} - (pbs_pkg::PROD_W + 1)'(qest_s2));
		qfix = (rem >= pbs_pkg::FULL_SCALE) ? qest_s2 + pbs_pkg::QEST_W'(1) : qest_s2;
		quo  = qfix[pbs_pkg::VAL_W-1:0];
	end
endmodule
`default_nettype wire

### design/pwm_synced_backemf_sampler_unit.sv
// Top level: ADC conversion sequencer for a PWM motor driver with back-EMF reporting.
//
//   channel  dir  handshake                     payload
//   evt      in   evt_valid / evt_stall         pbs_pkg::evt_t (operation, sample)
//   res      out  res_valid / res_stall         pbs_pkg::res_t
//   cfg      in   psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// One event per cycle while evt_stall is low; each transfer gives exactly one result, carried
// through the multiplier register, the divide-by-1023 correction stage and the output register.
// Sequencing state updates at accept, so back-to-back events see each other's effect.
// Three pipeline slots absorb a stalled output before evt_stall rises.
// arst_n clears sequencing state, pipeline valids and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module pwm_synced_backemf_sampler_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [3:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic      [31:0]    prdata,
	output logic                pready,
	input  wire logic           evt_valid,
	output logic                evt_stall,
	input  wire pbs_pkg::evt_t  evt,
	output logic                res_valid,
	input  wire logic           res_stall,
	output pbs_pkg::res_t       res
);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ON   = 2'd1;
	localparam logic [1:0] PH_OFF  = 2'd2;
	localparam logic [1:0] PH_POT  = 2'd3;

	logic [pbs_pkg::VAL_W-1:0] pwm_top_q;
	logic [pbs_pkg::VAL_W-1:0] supply_mv_q;
	logic [pbs_pkg::VAL_W-1:0] report_every_q;

	logic [1:0]                phase_q, phase_d;
	logic                      busy_q, busy_d;
	logic [pbs_pkg::VAL_W-1:0] pair_q, pair_d, pair_inc;
	logic [pbs_pkg::VAL_W-1:0] held_on_q;

	pbs_pkg::adv_t             adv;
	logic                      en_out;
	logic                      accept;
	logic                      cfg_wr;
	pbs_pkg::ctl_t             ctl_d, ctl_s1, ctl_s2;
	logic                      v_s1, v_s2, res_valid_q;
	logic [pbs_pkg::VAL_W-1:0] factor;
	logic [pbs_pkg::VAL_W-1:0] quo;
	pbs_pkg::res_t             res_d, res_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_top_q      <= pbs_pkg::PWM_TOP_RST;
			supply_mv_q    <= pbs_pkg::SUPPLY_MV_RST;
			report_every_q <= pbs_pkg::REPORT_EVERY_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				pbs_pkg::REG_PWM_TOP:      pwm_top_q      <= pwdata[15:0];
				pbs_pkg::REG_SUPPLY_MV:    supply_mv_q    <= pwdata[15:0];
				pbs_pkg::REG_REPORT_EVERY: report_every_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pbs_pkg::REG_PWM_TOP:      prdata = {16'b0, pwm_top_q};
			pbs_pkg::REG_SUPPLY_MV:    prdata = {16'b0, supply_mv_q};
			pbs_pkg::REG_REPORT_EVERY: prdata = {16'b0, report_every_q};
			default:                   prdata = 32'b0;
		endcase
	end

	// pipeline flow
	assign en_out    = !res_valid_q || !res_stall;
	assign adv.s2    = !v_s2 || en_out;
	assign adv.s1    = !v_s1 || adv.s2;
	assign evt_stall = !adv.s1;
	assign accept    = evt_valid && !evt_stall;

	// conversion sequencing
	always_comb begin
		ctl_d    = '0;
		phase_d  = phase_q;
		busy_d   = busy_q;
		pair_d   = pair_q;
		pair_inc = pair_q + pbs_pkg::VAL_W'(1);
		if (evt.operation inside {pbs_pkg::OP_BOTTOM, pbs_pkg::OP_TOP}) begin
			if (!busy_q) begin
				phase_d    = (evt.operation == pbs_pkg::OP_BOTTOM) ? PH_ON : PH_OFF;
				busy_d     = 1'b1;
				ctl_d.start = 1'b1;
				ctl_d.chan  = 1'b1;
			end
		end else if (evt.operation == pbs_pkg::OP_DONE) begin
			case (phase_q)
				PH_ON: begin
					ctl_d.hold  = 1'b1;
					ctl_d.start = 1'b1;
					phase_d     = PH_POT;
					busy_d      = 1'b1;
				end
				PH_POT: begin
					ctl_d.dvalid = 1'b1;
					phase_d      = PH_IDLE;
					busy_d       = 1'b0;
				end
				PH_OFF: begin
					phase_d = PH_IDLE;
					busy_d  = 1'b0;
					if (pair_inc >= report_every_q) begin
						pair_d       = '0;
						ctl_d.rvalid = 1'b1;
					end else begin
						pair_d = pair_inc;
					end
				end
				default: begin
					busy_d = 1'b0;
				end
			endcase
		end
	end

	assign factor = (phase_q == PH_POT) ? pwm_top_q : supply_mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			busy_q  <= 1'b0;
			pair_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			busy_q  <= busy_d;
			pair_q  <= pair_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv.s1) begin
				v_s1 <= accept;
			end
			if (adv.s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				res_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ctl_s1 <= ctl_d;
		end
		if (adv.s2) begin
			ctl_s2 <= ctl_s1;
		end
	end

	pbs_scale u_scale (
		.clk    (clk),
		.adv    (adv),
		.raw    (evt.sample),
		.factor (factor),
		.quo    (quo)
	);

	// result assembly
	always_comb begin
		res_d              = '0;
		res_d.start_conv   = ctl_s2.start;
		res_d.conv_channel = ctl_s2.start && ctl_s2.chan;
		res_d.duty_valid   = ctl_s2.dvalid;
		res_d.report_valid = ctl_s2.rvalid;
		if (ctl_s2.dvalid) begin
			res_d.duty = quo;
		end
		if (ctl_s2.rvalid) begin
			res_d.on_mv  = held_on_q;
			res_d.emf_mv = (quo <= supply_mv_q) ? supply_mv_q - quo : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_on_q <= '0;
		end else if (en_out && v_s2 && ctl_s2.hold) begin
			held_on_q <= quo;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $onehot0({res.start_conv, res.duty_valid, res.report_valid}))
		else $error("more than one result kind flagged");

	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (busy_q == (phase_q != PH_IDLE)))
		else $error("converter busy flag disagrees with phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		evt_stall |-> (v_s1 && v_s2 && res_valid_q))
		else $error("event stalled with a free pipeline slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted event lost from first stage");
endmodule
`default_nettype wire

### verif/pwm_synced_backemf_sampler_unit_test.sv
// Testbench for the back-EMF sampler: directed and random event streams checked against a predictor.
`timescale 1ns / 1ps
module pwm_synced_backemf_sampler_unit_test;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] SEQ_IDLE = 2'd0;
	localparam logic [1:0] SEQ_ON   = 2'd1;
	localparam logic [1:0] SEQ_OFF  = 2'd2;
	localparam logic [1:0] SEQ_POT  = 2'd3;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           psel = 1'b0;
	logic           penable = 1'b0;
	logic           pwrite = 1'b0;
	logic [3:0]     paddr = '0;
	logic [31:0]    pwdata = '0;
	logic [31:0]    prdata;
	logic           pready;
	logic           evt_valid = 1'b0;
	logic           evt_stall;
	pbs_pkg::evt_t  evt = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	pbs_pkg::res_t  res;

	pwm_synced_backemf_sampler_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #6 clk = ~clk;

	// predictor state and register copies
	logic [15:0] cfg_top = pbs_pkg::PWM_TOP_RST;
	logic [15:0] cfg_supply = pbs_pkg::SUPPLY_MV_RST;
	logic [15:0] cfg_every = pbs_pkg::REPORT_EVERY_RST;
	logic [1:0]  seq_phase = SEQ_IDLE;
	logic        conv_busy = 1'b0;
	logic [15:0] held_on_mv = '0;
	logic [15:0] pairs_done = '0;

	pbs_pkg::evt_t events_queue[$];
	pbs_pkg::res_t expected_results[$];
	int   err_count = 0;
	bit   evt_took = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;
	bit   hold_request = 1'b0;
	int   hold_left = 0;
	int unsigned stall_tick = 0;

	function automatic logic [15:0] scale_to(logic [9:0] raw, logic [15:0] span);
		int unsigned prod;
		prod = {22'd0, raw} * {16'd0, span};
		return 16'(prod / 1023);
	endfunction

	function automatic pbs_pkg::res_t predict_result(pbs_pkg::evt_t e);
		pbs_pkg::res_t r;
		logic [15:0] off_mv;
		r = '0;
		case (e.operation)
			pbs_pkg::OP_BOTTOM, pbs_pkg::OP_TOP: begin
				if (!conv_busy) begin
					seq_phase = (e.operation == pbs_pkg::OP_BOTTOM) ? SEQ_ON : SEQ_OFF;
					conv_busy = 1'b1;
					r.start_conv = 1'b1;
					r.conv_channel = 1'b1;
				end
			end
			pbs_pkg::OP_DONE: begin
				case (seq_phase)
					SEQ_ON: begin
						held_on_mv = scale_to(e.sample, cfg_supply);
						seq_phase = SEQ_POT;
						conv_busy = 1'b1;
						r.start_conv = 1'b1;
					end
					SEQ_POT: begin
						r.duty = scale_to(e.sample, cfg_top);
						r.duty_valid = 1'b1;
						seq_phase = SEQ_IDLE;
						conv_busy = 1'b0;
					end
					SEQ_OFF: begin
						off_mv = scale_to(e.sample, cfg_supply);
						seq_phase = SEQ_IDLE;
						conv_busy = 1'b0;
						pairs_done = pairs_done + 16'd1;
						if (pairs_done >= cfg_every) begin
							pairs_done = '0;
							r.report_valid = 1'b1;
							r.on_mv = held_on_mv;
							r.emf_mv = (off_mv <= cfg_supply) ? cfg_supply - off_mv : 16'd0;
						end
					end
					default: conv_busy = 1'b0;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
			err_count++;
		end
	endtask

	// event side: bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
		end else if (!(evt_valid && !evt_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				evt_valid <= 1'b0;
			end else if (events_queue.size() == 0) begin
				evt_valid <= 1'b0;
			end else begin
				evt_valid <= 1'b1;
				evt <= events_queue[0];
				evt_took = 1'b0;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && evt_valid && !evt_stall) begin
			expected_results.push_back(predict_result(evt));
			void'(events_queue.pop_front());
			evt_took = 1'b1;
		end
	end

	// result side: rotating stall pattern plus an occasional long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (hold_request) begin
			hold_left = 120;
			hold_request = 1'b0;
			res_stall <= 1'b1;
		end else begin
			stall_tick++;
			case ((stall_tick >> 6) % 4)
				0: res_stall <= 1'b0;
				1: res_stall <= ($urandom_range(0, 3) == 0);
				2: res_stall <= ($urandom_range(0, 3) != 0);
				default: res_stall <= (stall_tick % 4 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, got %h", $time, res);
				err_count++;
			end else begin
				pbs_pkg::res_t want;
				want = expected_results.pop_front();
				check_field("start_conv", 16'(want.start_conv), 16'(res.start_conv));
				check_field("conv_channel", 16'(want.conv_channel), 16'(res.conv_channel));
				check_field("duty_valid", 16'(want.duty_valid), 16'(res.duty_valid));
				check_field("duty", want.duty, res.duty);
				check_field("report_valid", 16'(want.report_valid), 16'(res.report_valid));
				check_field("on_mv", want.on_mv, res.on_mv);
				check_field("emf_mv", want.emf_mv, res.emf_mv);
			end
		end
	end

	task automatic set_register(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = {16'd0, val};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			pbs_pkg::REG_PWM_TOP: cfg_top = val;
			pbs_pkg::REG_SUPPLY_MV: cfg_supply = val;
			pbs_pkg::REG_REPORT_EVERY: cfg_every = val;
			default: ;
		endcase
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[15:0] !== val) begin
			$display("%0t: register %0d readback mismatch, expected %0d, got %0d",
				$time, idx, val, prdata[15:0]);
			err_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic program_settings(logic [15:0] top, logic [15:0] supply, logic [15:0] every);
		set_register(pbs_pkg::REG_PWM_TOP, top);
		set_register(pbs_pkg::REG_SUPPLY_MV, supply);
		set_register(pbs_pkg::REG_REPORT_EVERY, every);
	endtask

	task automatic wait_drained();
		while (events_queue.size() != 0 || expected_results.size() != 0 || evt_valid
				|| hold_request)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic void push_evt(logic [1:0] op, logic [9:0] smp);
		pbs_pkg::evt_t e;
		e.operation = op;
		e.sample = smp;
		events_queue.push_back(e);
	endfunction

	function automatic logic [9:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 10'd0;
			1: return 10'd1023;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [1:0] pick_edge();
		return $urandom_range(0, 1) ? pbs_pkg::OP_TOP : pbs_pkg::OP_BOTTOM;
	endfunction

	// mostly complete on/off conversion sequences, some noise and stray events
	function automatic void add_random_events(int n);
		int count;
		int pick;
		count = 0;
		while (count < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				push_evt(pbs_pkg::OP_BOTTOM, pick_sample());
				if ($urandom_range(0, 9) == 0) push_evt(pick_edge(), pick_sample());
				push_evt(pbs_pkg::OP_DONE, pick_sample());
				if ($urandom_range(0, 9) == 0) push_evt(pick_edge(), pick_sample());
				push_evt(pbs_pkg::OP_DONE, pick_sample());
				count += 3;
			end else if (pick < 85) begin
				push_evt(pbs_pkg::OP_TOP, pick_sample());
				if ($urandom_range(0, 9) == 0) push_evt(pick_edge(), pick_sample());
				push_evt(pbs_pkg::OP_DONE, pick_sample());
				count += 2;
			end else begin
				push_evt(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
				count += 1;
			end
		end
	endfunction

	initial begin
		logic [15:0] tops[7];
		logic [15:0] supplies[7];
		logic [15:0] everys[7];
		tops = '{16'd65535, 16'd0, 16'd1, 16'd777, 16'd0, 16'd65535, 16'd1000};
		supplies = '{16'd65535, 16'd0, 16'd1023, 16'd3300, 16'd0, 16'd1, 16'd5000};
		everys = '{16'd2, 16'd0, 16'd65535, 16'd3, 16'd1, 16'd5, 16'd50};
		tops[4] = 16'($urandom_range(1, 65535));
		supplies[4] = 16'($urandom_range(0, 65535));
		everys[4] = 16'($urandom_range(1, 8));
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		program_settings(16'd1000, 16'd5000, 16'd1);
		push_evt(pbs_pkg::OP_DONE, 10'd0);
		push_evt(OP_UNUSED, 10'd1023);
		push_evt(pbs_pkg::OP_BOTTOM, 10'd0);
		push_evt(pbs_pkg::OP_TOP, 10'd1023);
		push_evt(pbs_pkg::OP_BOTTOM, 10'd0);
		push_evt(pbs_pkg::OP_DONE, 10'd1023);
		push_evt(pbs_pkg::OP_DONE, 10'd1023);
		push_evt(pbs_pkg::OP_TOP, 10'd0);
		push_evt(pbs_pkg::OP_DONE, 10'd0);
		push_evt(pbs_pkg::OP_BOTTOM, 10'd1023);
		push_evt(pbs_pkg::OP_DONE, 10'd0);
		push_evt(pbs_pkg::OP_DONE, 10'd0);
		push_evt(pbs_pkg::OP_TOP, 10'd1023);
		push_evt(pbs_pkg::OP_DONE, 10'd1023);
		push_evt(pbs_pkg::OP_DONE, 10'd512);
		push_evt(pbs_pkg::OP_BOTTOM, 10'd0);
		push_evt(pbs_pkg::OP_DONE, 10'h155);
		push_evt(pbs_pkg::OP_DONE, 10'h2AA);
		push_evt(pbs_pkg::OP_TOP, 10'd0);
		push_evt(OP_UNUSED, 10'd0);
		push_evt(pbs_pkg::OP_DONE, 10'd1023);
		wait_drained();

		// back to the register defaults
		program_settings(pbs_pkg::PWM_TOP_RST, pbs_pkg::SUPPLY_MV_RST,
			pbs_pkg::REPORT_EVERY_RST);
		add_random_events(150);
		wait_drained();

		for (int i = 0; i < 7; i++) begin
			program_settings(tops[i], supplies[i], everys[i]);
			add_random_events(160);
			if (i == 0 || i == 5) hold_request = 1'b1;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("pwm_synced_backemf_sampler_unit test passed");
		else
			$display("pwm_synced_backemf_sampler_unit test failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("pwm_synced_backemf_sampler_unit test failed");
		$finish;
	end
endmodule

### sim.f
design/pbs_pkg.sv
design/pbs_scale.sv
design/pwm_synced_backemf_sampler_unit.sv
verif/pwm_synced_backemf_sampler_unit_test.sv
